/* hdl/complex_natural_log_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the complex logarithm block
// Shorthand for clocked implications, reset-qualified, reported by $error.
// ---------------------------------------------------------------------------
`ifndef COMPLEX_NATURAL_LOG_ASSERT_SVH
`define COMPLEX_NATURAL_LOG_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define CNL_AST_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CNL_AST_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/cnl_pkg.sv */
// ---------------------------------------------------------------------------
// cnl_pkg
// Shared constants and divider interface types for the complex logarithm.
// ---------------------------------------------------------------------------
package cnl_pkg;

	localparam int ITERATIONS = 32;
	localparam int TBL_LEN    = ITERATIONS + 1;
	localparam int AW         = $clog2(TBL_LEN);
	localparam int JOBS       = 2 * ITERATIONS + 3;
	localparam int JW         = $clog2(JOBS);
	localparam int DIV_BITS   = 64;
	localparam int DCW        = $clog2(DIV_BITS + 1);

	localparam logic [63:0]        ONE62  = 64'd1 << 62;
	localparam logic signed [27:0] PI_Q24 = 28'sd52707179;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [63:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;

endpackage

/* hdl/cnl_div.sv */
// ---------------------------------------------------------------------------
// cnl_div
// Unsigned 64 by 64 restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module cnl_div (
	input  logic              clk,
	input  logic              arst_n,
	input  cnl_pkg::div_req_t req,
	output cnl_pkg::div_rsp_t rsp
);
	import cnl_pkg::*;

	logic           busy_q;
	logic           done_q;
	logic [DCW-1:0] cnt_q;
	logic [63:0]    rem_q;
	logic [63:0]    quo_q;
	logic [63:0]    dvs_q;
	logic [64:0]    rs;
	logic [64:0]    rs_sub;
	logic           fits;

	assign rs     = {rem_q, quo_q[63]};
	assign rs_sub = rs - {1'b0, dvs_q};
	assign fits   = rs >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DCW'(DIV_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DCW'(1);
			if (cnt_q == DCW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rs_sub[63:0] : rs[63:0];
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

/* hdl/complex_natural_log.sv */
// ---------------------------------------------------------------------------
// complex_natural_log
// Complex natural logarithm w = ln(z): log modulus and principal angle.
// ---------------------------------------------------------------------------
// Usage: the input stream carries z, real part in s_axis_tdata[31:0] and
// imaginary part in s_axis_tdata[63:32], both signed Q16.16. Every input
// transfer yields exactly one output transfer: ln|z| in m_axis_tdata[31:0]
// (signed Q8.24) and arg(z) in m_axis_tdata[58:32] (signed Q3.24), with m_axis_tuser
// flagging a zero input (most negative log, angle zero).
// After reset the block builds its atan(2^-k) and ln(1+2^-k) tables with the
// shared divider, evaluating each series term by term; s_axis_tready stays
// low until the build pass is done.
// After its input transfer, an item passes through three squaring states, a
// six-step normalization, ITERATIONS combined log and CORDIC steps, a state to
// start the divider, one or two waits on the one bit-serial divider for the
// residual corrections, which set most of the latency, six multiply steps, a
// rounding state and an output state.
// A zero input goes straight from idle to the output state.
// One item is in flight at a time; s_axis_tready is high only when idle, so
// a new item is taken only once the last result is in the output register.
// A finished result sits in the output register until the receiver takes it;
// while it stalls, the next item may be accepted, but its result waits.
// ---------------------------------------------------------------------------
module complex_natural_log (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [31:0] re_part, [63:32] im_part
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [31:0] log_magnitude, [58:32] angle, rest zero
	output logic        m_axis_tuser    // [0] zero_input
);
	import cnl_pkg::*;

	// Sequencer states: table build pass first, then per-item work.
	localparam logic [4:0] S_BLD_JOB = 5'd0;
	localparam logic [4:0] S_BLD_WPW = 5'd1;
	localparam logic [4:0] S_BLD_CHK = 5'd2;
	localparam logic [4:0] S_BLD_WT  = 5'd3;
	localparam logic [4:0] S_BLD_WQ1 = 5'd4;
	localparam logic [4:0] S_BLD_WQ2 = 5'd5;
	localparam logic [4:0] S_BLD_WR  = 5'd6;
	localparam logic [4:0] S_IDLE    = 5'd7;
	localparam logic [4:0] S_SQ1     = 5'd8;
	localparam logic [4:0] S_SQ2     = 5'd9;
	localparam logic [4:0] S_SQ3     = 5'd10;
	localparam logic [4:0] S_NRM     = 5'd11;
	localparam logic [4:0] S_ITR     = 5'd12;
	localparam logic [4:0] S_LDIV    = 5'd13;
	localparam logic [4:0] S_LDW     = 5'd14;
	localparam logic [4:0] S_ADW     = 5'd15;
	localparam logic [4:0] S_MUL     = 5'd16;
	localparam logic [4:0] S_RND     = 5'd17;
	localparam logic [4:0] S_FIN     = 5'd18;

	logic [4:0]    state_q;
	logic [JW-1:0] jb_q;
	logic [AW-1:0] it_q;
	logic [2:0]    step_q;

	// Output register
	logic        ovalid_q;
	logic [31:0] olm_q;
	logic [26:0] oang_q;
	logic        ozero_q;
	logic        out_load;

	// Table build working registers
	logic [63:0] q_q;
	logic [63:0] pw_q;
	logic [63:0] sum_q;
	logic [63:0] s5_q;
	logic [6:0]  n_q;
	logic        alt_q;

	// Per-item working registers
	logic [31:0]        are_q;
	logic [31:0]        aim_q;
	logic [31:0]        mx_q;
	logic               neg_re_q;
	logic               im_neg_q;
	logic               imz_q;
	logic               zero_q;
	logic [63:0]        sq_q;
	logic [63:0]        m_q;
	logic [63:0]        x_q;
	logic [63:0]        acc_q;
	logic [5:0]         lz_q;
	logic signed [63:0] cx_q;
	logic signed [63:0] cy_q;
	logic signed [63:0] z_q;
	logic signed [63:0] base_q;
	logic [63:0]        mcand_q;
	logic [63:0]        prod_q;
	logic [5:0]         mplier_q;
	logic [31:0]        lm_q;
	logic [26:0]        ang_q;

	// Constant tables in Q2.62, filled by the build pass
	logic [63:0]   atan_mem [TBL_LEN];
	logic [63:0]   lnp_mem  [TBL_LEN];
	logic [63:0]   atan_rd_q;
	logic [63:0]   lnp_rd_q;
	logic [AW-1:0] atan_ra;
	logic [AW-1:0] lnp_ra;
	logic [AW:0]   it2;
	logic          atan_we;
	logic          lnp_we;
	logic [AW-1:0] tbl_wa;
	logic [63:0]   tbl_wd;

	div_req_t dreq;
	div_rsp_t drsp;

	cnl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// ---------------------------------------------------------------
	// Input decode
	// ---------------------------------------------------------------
	logic signed [31:0] in_re;
	logic signed [31:0] in_im;
	logic [31:0]        in_are;
	logic [31:0]        in_aim;
	logic signed [32:0] in_cy;
	logic               in_zero;
	logic               in_take;

	assign in_re   = $signed(s_axis_tdata[31:0]);
	assign in_im   = $signed(s_axis_tdata[63:32]);
	// Negating the most negative value yields 2^31 as an unsigned pattern.
	assign in_are  = in_re[31] ? 32'(-in_re) : in_re;
	assign in_aim  = in_im[31] ? 32'(-in_im) : in_im;
	// Left half-plane points are folded by negating both parts.
	assign in_cy   = in_re[31] ? -{in_im[31], in_im} : {in_im[31], in_im};
	assign in_zero = (in_re == 32'sd0) && (in_im == 32'sd0);
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_take = s_axis_tvalid && s_axis_tready;

	// ---------------------------------------------------------------
	// Table build helpers: job 0 is the series at 5, job 1 at 239 (they
	// combine into atan(1)), then atan(2^-k), then ln(1+2^-k).
	// ---------------------------------------------------------------
	logic [JW-1:0] jb_m1;
	logic [JW-1:0] jb_mi1;
	logic [JW-1:0] jb_mi2;
	logic [63:0]   q_next;
	logic          alt_next;
	logic [63:0]   odd_div;

	assign jb_m1    = jb_q - JW'(1);
	assign jb_mi1   = jb_q - JW'(ITERATIONS + 1);
	assign jb_mi2   = jb_q - JW'(ITERATIONS + 2);
	assign alt_next = jb_q <= JW'(ITERATIONS + 1);
	assign odd_div  = 64'({n_q, 1'b1});

	always_comb begin
		if (jb_q == JW'(0)) begin
			q_next = 64'd5;
		end else if (jb_q == JW'(1)) begin
			q_next = 64'd239;
		end else if (alt_next) begin
			q_next = 64'd1 << jb_m1;
		end else begin
			q_next = (64'd1 << jb_mi1) + 64'd1;
		end
	end

	always_comb begin
		atan_we = 1'b0;
		lnp_we  = 1'b0;
		tbl_wa  = '0;
		tbl_wd  = sum_q;
		if (state_q == S_BLD_WR && jb_q != JW'(0)) begin
			if (jb_q == JW'(1)) begin
				atan_we = 1'b1;
				tbl_wd  = (s5_q << 2) - sum_q;
			end else if (alt_q) begin
				atan_we = 1'b1;
				tbl_wa  = jb_m1[AW-1:0];
			end else begin
				lnp_we  = 1'b1;
				tbl_wa  = jb_mi2[AW-1:0];
				tbl_wd  = sum_q << 1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Per-item datapath helpers
	// ---------------------------------------------------------------
	logic [5:0]         sh6;
	logic               m_hi_zero;
	logic               mx_hi_zero;
	logic [63:0]        y_w;
	logic [AW-1:0]      ksh;
	logic [63:0]        t_w;
	logic               take;
	logic signed [63:0] cx_sh;
	logic signed [63:0] cy_sh;
	logic signed [63:0] a60;
	logic signed [63:0] atv;
	logic [63:0]        diff_w;
	logic [63:0]        diff_c;
	logic signed [63:0] d_w;
	logic               d_pos;
	logic [63:0]        cy_abs;
	logic signed [63:0] qs;
	logic               pneg;
	logic [5:0]         pmag;
	logic [63:0]        total;
	logic [63:0]        lm_u;
	logic signed [31:0] lm_w;
	logic signed [63:0] av;
	logic [63:0]        au;
	logic signed [27:0] af;
	logic signed [27:0] af_c;

	assign sh6        = 6'd32 >> step_q;
	assign m_hi_zero  = (m_q >> (7'd64 - {1'b0, sh6})) == 64'd0;
	assign mx_hi_zero = (mx_q >> (6'd32 - sh6)) == 32'd0;
	assign y_w        = {1'b0, m_q[63:1]};

	// Shift-and-add logarithm step uses factor 1+2^-(it+1).
	assign ksh  = it_q + AW'(1);
	assign t_w  = x_q + (x_q >> ksh);
	assign take = t_w <= y_w;

	// CORDIC vectoring step uses angle atan(2^-it), kept in Q4.60.
	assign cx_sh = cx_q >>> it_q;
	assign cy_sh = cy_q >>> it_q;
	assign a60   = $signed({2'b00, atan_rd_q[63:2]});
	assign atv   = $signed(atan_rd_q);

	// First-order residual corrections.
	assign diff_w = y_w - x_q;
	assign diff_c = (diff_w > (64'd1 << 47)) ? (64'd1 << 47) : diff_w;
	assign d_w    = cx_q >>> 40;
	assign d_pos  = d_w > 64'sd0;
	assign cy_abs = cy_q[63] ? 64'(-cy_q) : 64'(cy_q);
	assign qs     = cy_q[63] ? -$signed(drsp.quotient) : $signed(drsp.quotient);

	// Exponent term: p - 32 = 31 - lz, applied by shift-and-add.
	assign pneg = lz_q > 6'd31;
	assign pmag = pneg ? (lz_q - 6'd31) : (6'd31 - lz_q);

	// Round to nearest, ties up: bias to positive, add half, floor.
	assign total = (pneg ? -prod_q : prod_q) + (acc_q >> 6);
	assign lm_u  = total + ONE62 + (64'd1 << 32);
	assign lm_w  = $signed({1'b0, lm_u[63:33]}) - 32'sd536870912;
	assign av    = base_q + z_q;
	assign au    = 64'(av) + ONE62 + (64'd1 << 35);
	assign af    = $signed({1'b0, au[62:36]}) - 28'sd67108864;

	always_comb begin
		if (af > PI_Q24) begin
			af_c = PI_Q24;
		end else if (af < -PI_Q24) begin
			af_c = -PI_Q24;
		end else begin
			af_c = af;
		end
		// Points on the real axis get exact angles.
		if (imz_q) begin
			af_c = neg_re_q ? PI_Q24 : 28'sd0;
		end
	end

	// ---------------------------------------------------------------
	// Table read addresses, issued in the cycle before use
	// ---------------------------------------------------------------
	assign it2 = {1'b0, it_q} + (AW + 1)'(2);

	always_comb begin
		atan_ra = '0;
		lnp_ra  = '0;
		if (state_q == S_NRM && step_q == 3'd5) begin
			lnp_ra = AW'(1);
		end else if (state_q == S_ITR) begin
			atan_ra = it_q + AW'(1);
			lnp_ra  = (it2 > (AW + 1)'(TBL_LEN - 1)) ? AW'(TBL_LEN - 1) : it2[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (atan_we) begin
			atan_mem[tbl_wa] <= tbl_wd;
		end
		if (lnp_we) begin
			lnp_mem[tbl_wa] <= tbl_wd;
		end
		atan_rd_q <= atan_mem[atan_ra];
		lnp_rd_q  <= lnp_mem[lnp_ra];
	end

	// ---------------------------------------------------------------
	// Divider requests
	// ---------------------------------------------------------------
	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = '0;
		dreq.divisor  = '0;
		case (state_q)
			S_BLD_JOB: begin
				dreq.start    = 1'b1;
				dreq.dividend = ONE62;
				dreq.divisor  = q_next;
			end
			S_BLD_CHK: begin
				dreq.start    = pw_q != 64'd0;
				dreq.dividend = pw_q;
				dreq.divisor  = odd_div;
			end
			S_BLD_WT: begin
				dreq.start    = drsp.done;
				dreq.dividend = pw_q;
				dreq.divisor  = q_q;
			end
			S_BLD_WQ1: begin
				dreq.start    = drsp.done;
				dreq.dividend = drsp.quotient;
				dreq.divisor  = q_q;
			end
			S_LDIV: begin
				dreq.start    = 1'b1;
				dreq.dividend = diff_c << 16;
				dreq.divisor  = x_q >> 46;
			end
			S_LDW: begin
				dreq.start    = drsp.done && d_pos;
				dreq.dividend = cy_abs;
				dreq.divisor  = 64'(d_w);
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	assign out_load = (state_q == S_FIN) && (!ovalid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_BLD_JOB;
			jb_q     <= '0;
			it_q     <= '0;
			step_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_BLD_JOB: state_q <= S_BLD_WPW;
				S_BLD_WPW: if (drsp.done) state_q <= S_BLD_CHK;
				S_BLD_CHK: state_q <= (pw_q == 64'd0) ? S_BLD_WR : S_BLD_WT;
				S_BLD_WT:  if (drsp.done) state_q <= S_BLD_WQ1;
				S_BLD_WQ1: if (drsp.done) state_q <= S_BLD_WQ2;
				S_BLD_WQ2: if (drsp.done) state_q <= S_BLD_CHK;
				S_BLD_WR: begin
					if (jb_q == JW'(JOBS - 1)) begin
						state_q <= S_IDLE;
					end else begin
						jb_q    <= jb_q + JW'(1);
						state_q <= S_BLD_JOB;
					end
				end
				S_IDLE: begin
					if (in_take) begin
						state_q <= in_zero ? S_FIN : S_SQ1;
					end
				end
				S_SQ1: state_q <= S_SQ2;
				S_SQ2: state_q <= S_SQ3;
				S_SQ3: begin
					step_q  <= '0;
					state_q <= S_NRM;
				end
				S_NRM: begin
					if (step_q == 3'd5) begin
						it_q    <= '0;
						state_q <= S_ITR;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_ITR: begin
					if (it_q == AW'(ITERATIONS - 1)) begin
						state_q <= S_LDIV;
					end else begin
						it_q <= it_q + AW'(1);
					end
				end
				S_LDIV: state_q <= S_LDW;
				S_LDW: begin
					if (drsp.done) begin
						step_q  <= '0;
						state_q <= d_pos ? S_ADW : S_MUL;
					end
				end
				S_ADW: begin
					if (drsp.done) begin
						step_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (step_q == 3'd5) begin
						state_q <= S_RND;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_RND: state_q <= S_FIN;
				S_FIN: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Datapath registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			S_BLD_JOB: begin
				q_q   <= q_next;
				alt_q <= alt_next;
				n_q   <= '0;
				sum_q <= '0;
			end
			S_BLD_WPW: if (drsp.done) pw_q <= drsp.quotient;
			S_BLD_WT: begin
				if (drsp.done) begin
					sum_q <= (alt_q && n_q[0]) ? (sum_q - drsp.quotient)
					                           : (sum_q + drsp.quotient);
				end
			end
			S_BLD_WQ2: begin
				if (drsp.done) begin
					pw_q <= drsp.quotient;
					n_q  <= n_q + 7'd1;
				end
			end
			S_BLD_WR: if (jb_q == JW'(0)) s5_q <= sum_q;
			S_IDLE: begin
				are_q    <= in_are;
				aim_q    <= in_aim;
				mx_q     <= (in_are > in_aim) ? in_are : in_aim;
				neg_re_q <= in_re[31];
				im_neg_q <= in_im[31];
				imz_q    <= in_im == 32'sd0;
				zero_q   <= in_zero;
				cx_q     <= $signed({5'd0, in_are, 27'd0});
				cy_q     <= $signed({{4{in_cy[32]}}, in_cy, 27'd0});
				lm_q     <= 32'h8000_0000;
				ang_q    <= '0;
			end
			S_SQ1: sq_q <= are_q * are_q;
			S_SQ2: begin
				m_q     <= sq_q;
				sq_q    <= aim_q * aim_q;
				base_q  <= !neg_re_q ? 64'sd0 : (im_neg_q ? -atv : atv);
				mcand_q <= lnp_rd_q >> 6;
			end
			S_SQ3: begin
				m_q   <= m_q + sq_q;
				lz_q  <= '0;
				x_q   <= ONE62;
				acc_q <= '0;
				z_q   <= '0;
			end
			S_NRM: begin
				if (m_hi_zero) begin
					m_q  <= m_q << sh6;
					lz_q <= lz_q + sh6;
				end
				if (mx_hi_zero) begin
					mx_q <= mx_q << sh6;
					cx_q <= cx_q <<< sh6;
					cy_q <= cy_q <<< sh6;
				end
			end
			S_ITR: begin
				if (take) begin
					x_q   <= t_w;
					acc_q <= acc_q + lnp_rd_q;
				end
				if (!cy_q[63]) begin
					cx_q <= cx_q + cy_sh;
					cy_q <= cy_q - cx_sh;
					z_q  <= z_q + a60;
				end else begin
					cx_q <= cx_q - cy_sh;
					cy_q <= cy_q + cx_sh;
					z_q  <= z_q - a60;
				end
			end
			S_LDIV: begin
				mplier_q <= pmag;
				prod_q   <= '0;
			end
			S_LDW: if (drsp.done) acc_q <= acc_q + drsp.quotient;
			S_ADW: if (drsp.done) z_q <= z_q + (qs <<< 20);
			S_MUL: begin
				if (mplier_q[0]) begin
					prod_q <= prod_q + mcand_q;
				end
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end
			S_RND: begin
				lm_q  <= lm_w;
				ang_q <= af_c[26:0];
			end
			default: begin
			end
		endcase
		if (out_load) begin
			olm_q   <= lm_q;
			oang_q  <= ang_q;
			ozero_q <= zero_q;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {5'd0, oang_q, olm_q};
	assign m_axis_tuser  = ozero_q;

endmodule

/* hdl/cnl_checker.sv */
// ---------------------------------------------------------------------------
// cnl_checker
// Port-level checks on the complex logarithm block, bound to its top level.
// ---------------------------------------------------------------------------
`include "complex_natural_log_assert.svh"

module cnl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// A stalled result must hold until it is taken.
	`CNL_AST_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output changed while stalled")

	// One item at a time: the cycle after an input transfer the block is busy.
	`CNL_AST_NEXT(a_busy_after_take, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted back to back")

	// A zero input gives the most negative log and a zero angle.
	`CNL_AST_SAME(a_zero_result, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[31:0] == 32'h8000_0000 && m_axis_tdata[58:32] == 27'd0, "wrong result for zero input")

	// The angle stays in the principal range.
	`CNL_AST_SAME(a_angle_range, clk, arst_n, m_axis_tvalid, $signed(m_axis_tdata[58:32]) <= 27'sd52707179 && $signed(m_axis_tdata[58:32]) >= -27'sd52707179 && m_axis_tdata[63:59] == 5'd0, "angle out of range")

endmodule

bind complex_natural_log cnl_checker u_cnl_checker (.*);
